FILE: sv/kseq_pkg.sv
// ----------------------------------------------------------------------------
// kseq_pkg
// Types and codes shared by the keyed sequence counter table.
// ----------------------------------------------------------------------------
package kseq_pkg;

  localparam int KEY_W = 64;
  localparam int CNT_W = 32;
  localparam int CMD_W = 2;
  localparam int STS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // table write request
  typedef struct packed {
    logic                    key_en;
    logic                    cnt_en;
    logic [KEY_W-1:0]        key;
    logic signed [CNT_W-1:0] cnt;
  } tbl_wr_t;

endpackage

FILE: sv/kseq_table.sv
// ----------------------------------------------------------------------------
// kseq_table
// Key and counter storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kseq_table #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                             clk,
  input  kseq_pkg::tbl_wr_t                wr,
  input  logic [IDX_W-1:0]                 wr_addr,
  input  logic [IDX_W-1:0]                 rd_addr,
  output logic [kseq_pkg::KEY_W-1:0]       rd_key,
  output logic signed [kseq_pkg::CNT_W-1:0] rd_count
);
  import kseq_pkg::*;

  logic [KEY_W-1:0]        mem_key   [ENTRIES];
  logic signed [CNT_W-1:0] mem_count [ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      mem_key[wr_addr] <= wr.key;
    end
    if (wr.cnt_en) begin
      mem_count[wr_addr] <= wr.cnt;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key   <= mem_key[rd_addr];
    rd_count <= mem_count[rd_addr];
  end

endmodule

FILE: sv/keyed_sequence_counter_table_top.sv
// ----------------------------------------------------------------------------
// keyed_sequence_counter_table_top
// Associative key to sequence counter table, scanned one slot a cycle.
// ----------------------------------------------------------------------------
// A hit ends the scan early. A new request is taken only in idle, once the
// scan, update and result hand-off of the last one are through; the single
// key comparator walks the table slot by slot.
// Reset: synchronous, clears all valid bits and the handshake state; no
// clearing pass is needed.
module keyed_sequence_counter_table_top #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // key[63:0], start_value[95:64]
  input  logic [1:0]   s_tuser,   // command[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // value[31:0]
  output logic [1:0]   m_tuser    // status[1:0]
);
  import kseq_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t                  state;
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        rd_addr;
  logic [CMD_W-1:0]        req_cmd;
  logic [KEY_W-1:0]        req_key;
  logic signed [CNT_W-1:0] req_start;
  logic                    hit;
  logic [IDX_W-1:0]        hit_idx;
  logic signed [CNT_W-1:0] hit_count;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [STS_W-1:0]        res_status;
  logic signed [CNT_W-1:0] res_value;
  logic [STS_W-1:0]        upd_status;
  logic signed [CNT_W-1:0] upd_value;
  logic                    out_valid;
  logic                    out_load;
  logic [STS_W-1:0]        out_status;
  logic signed [CNT_W-1:0] out_value;
  logic [KEY_W-1:0]        rd_key;
  logic signed [CNT_W-1:0] rd_count;
  logic                    key_match;
  logic                    scan_last;
  tbl_wr_t                 wr;
  logic [IDX_W-1:0]        wr_addr;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_value;
  assign m_tuser  = out_status;

  // shared key comparator on the slot under scan
  assign key_match = valid[idx] && (rd_key == req_key);
  assign scan_last = (idx == LAST_IDX);

  // read address runs one slot ahead of the comparator
  always_comb begin
    if (state == S_SCAN && !scan_last) begin
      rd_addr = idx + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  // outcome and table write for the finished scan
  always_comb begin
    upd_status = ST_OK;
    upd_value  = '0;
    wr.key_en  = 1'b0;
    wr.cnt_en  = 1'b0;
    wr.key     = req_key;
    wr.cnt     = req_start;
    wr_addr    = free_idx;
    if (state == S_UPD) begin
      case (req_cmd)
        CMD_INSERT: begin
          if (hit) begin
            upd_status = ST_PRESENT;
          end else if (!free_found) begin
            upd_status = ST_FULL;
          end else begin
            wr.key_en = 1'b1;
            wr.cnt_en = 1'b1;
          end
        end
        CMD_NEXT: begin
          wr_addr = hit_idx;
          wr.cnt  = hit_count + CNT_W'(1);
          if (hit) begin
            upd_value = hit_count;
            wr.cnt_en = 1'b1;
          end else begin
            upd_status = ST_MISSING;
          end
        end
        CMD_ERASE: begin
          if (!hit) begin
            upd_status = ST_MISSING;
          end
        end
        default: begin
          upd_status = ST_OK;
        end
      endcase
    end
  end

  kseq_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_count (rd_count)
  );

  // result register loads once the previous result has gone
  assign out_load = (state == S_DONE) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_value  <= res_value;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_cmd    <= s_tuser;
            req_key    <= s_tdata[63:0];
            req_start  <= s_tdata[95:64];
            idx        <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!valid[idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= idx;
          end
          if (key_match) begin
            hit       <= 1'b1;
            hit_idx   <= idx;
            hit_count <= rd_count;
          end
          if (key_match || scan_last) begin
            state <= S_UPD;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_UPD: begin
          if (req_cmd == CMD_INSERT && !hit && free_found) begin
            valid[free_idx] <= 1'b1;
          end
          if (req_cmd == CMD_ERASE && hit) begin
            valid[hit_idx] <= 1'b0;
          end
          res_status <= upd_status;
          res_value  <= upd_value;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while a scan is in flight");

  // a hit always points at a live slot
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && hit |-> valid[hit_idx])
    else $error("hit on an empty slot");

  // table full is only reported when every slot is live
  a_full_real: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && (upd_status == ST_FULL) |-> (&valid))
    else $error("table full reported with a free slot");

  // a successful insert adds exactly one live slot
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) && (req_cmd == CMD_INSERT) && !hit && free_found
    |=> $countones(valid) == $past($countones(valid)) + 1)
    else $error("insert did not add one slot");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the keyed sequence counter table.
// A driver offers insert, fetch-and-increment, erase and no-op requests from a
// backlog, a monitor checks every result against a table kept alongside, and
// the idling mix of both sides changes from phase to phase, with one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kseq_pkg::*;

  localparam int        SLOTS      = 16;
  localparam int        CYCLE_CAP  = 300000;
  localparam int        HOLD_LEN   = 300;
  localparam int        DRAIN_WAIT = 40;
  localparam int        POOL_SIZE  = 24;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] start;
  } cnt_req_t;

  typedef struct {
    logic [STS_W-1:0] status;
    logic [CNT_W-1:0] value;
  } cnt_resp_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [95:0]  s_tdata;   // key[63:0], start_value[95:64]
  logic [1:0]   s_tuser;   // command[1:0]
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // value[31:0]
  logic [1:0]   m_tuser;   // status[1:0]

  cnt_req_t  req_backlog[$];
  cnt_resp_t due_results[$];

  // shadow of the counter table
  logic             shadow_valid [SLOTS];
  logic [KEY_W-1:0] shadow_key   [SLOTS];
  logic [CNT_W-1:0] shadow_count [SLOTS];

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int n_sent;
  int n_taken;
  int n_errors;
  int cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  bit hold_req;
  bit hold_started;

  keyed_sequence_counter_table_top #(
    .TABLE_ENTRIES(SLOTS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // apply one request to the shadow table and return what the block should say
  task automatic count_table_step(input cnt_req_t r, output cnt_resp_t resp);
    int hit;
    int free_idx;
    hit = -1;
    free_idx = -1;
    resp.status = ST_OK;
    resp.value  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (shadow_valid[i] && shadow_key[i] == r.key) hit = i;
      if (!shadow_valid[i]) free_idx = i;
    end
    case (r.cmd)
      CMD_INSERT: begin
        if (hit >= 0) begin
          resp.status = ST_PRESENT;
        end else if (free_idx < 0) begin
          resp.status = ST_FULL;
        end else begin
          shadow_valid[free_idx] = 1'b1;
          shadow_key[free_idx]   = r.key;
          shadow_count[free_idx] = r.start;
        end
      end
      CMD_NEXT: begin
        if (hit < 0) begin
          resp.status = ST_MISSING;
        end else begin
          resp.value        = shadow_count[hit];
          shadow_count[hit] = shadow_count[hit] + 32'd1;
        end
      end
      CMD_ERASE: begin
        if (hit < 0) resp.status = ST_MISSING;
        else shadow_valid[hit] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [1:0] cmd, input logic [63:0] key,
                          input logic [31:0] start);
    cnt_req_t r;
    r.cmd   = cmd;
    r.key   = key;
    r.start = start;
    req_backlog.push_back(r);
  endtask

  function automatic logic [31:0] pick_start();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFE;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // mostly pool keys so hits, fills and erases happen; some fresh keys as noise
  function automatic cnt_req_t random_req();
    cnt_req_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 35)      r.cmd = CMD_INSERT;
    else if (roll < 75) r.cmd = CMD_NEXT;
    else if (roll < 95) r.cmd = CMD_ERASE;
    else                r.cmd = CMD_NOP;
    if ($urandom_range(9) == 0) r.key = {$urandom, $urandom};
    else r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    r.start = pick_start();
    return r;
  endfunction

  // request driver: holds a request until taken, then maybe idles
  always @(negedge clk) begin
    cnt_req_t r;
    if (!rst && n_taken == n_sent) begin
      if (req_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        r = req_backlog.pop_front();
        s_tdata  <= {r.start, r.key};
        s_tuser  <= r.cmd;
        s_tvalid <= 1'b1;
        n_sent++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left    = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: check results first, then predict for a newly taken request
  always @(posedge clk) begin
    cnt_req_t  r;
    cnt_resp_t p;
    cnt_resp_t e;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result status %0d value %h", $realtime,
                   m_tuser, m_tdata);
          n_errors++;
        end else begin
          e = due_results.pop_front();
          if (m_tuser !== e.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $realtime,
                     e.status, m_tuser);
            n_errors++;
          end
          if (m_tdata !== e.value) begin
            $display("%0t: value mismatch expected %h actual %h", $realtime,
                     e.value, m_tdata);
            n_errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        r.key   = s_tdata[63:0];
        r.start = s_tdata[95:64];
        r.cmd   = s_tuser;
        count_table_step(r, p);
        due_results.push_back(p);
        n_taken++;
      end
    end
  end

  // cycle cap
  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("** keyed_sequence_counter_table_top: FAILED **");
    $finish;
  end

  // stimulus and phase control
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    n_sent       = 0;
    n_taken      = 0;
    n_errors     = 0;
    hold_left    = 0;
    hold_req     = 1'b0;
    hold_started = 1'b0;
    tx_idle_pct  = 6;
    rx_idle_pct  = 87;
    for (int i = 0; i < SLOTS; i++) shadow_valid[i] = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
    // near neighbours: differ from another pool key in a single bit
    key_pool[2] = key_pool[3] ^ (64'd1 << $urandom_range(63));
    key_pool[4] = key_pool[5] ^ (64'd1 << $urandom_range(63));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty table, duplicate, counter wrap, no-op, fill up, full
    push_req(CMD_NEXT,   64'd0, 32'd0);
    push_req(CMD_ERASE,  64'd0, 32'hFFFF_FFFF);
    push_req(CMD_INSERT, 64'd0, 32'h7FFF_FFFF);
    push_req(CMD_INSERT, 64'd0, 32'd0);
    push_req(CMD_NEXT,   64'd0, 32'd0);
    push_req(CMD_NEXT,   64'd0, 32'd0);
    push_req(CMD_NOP,    '1,    32'hFFFF_FFFF);
    push_req(CMD_INSERT, '1,    32'h8000_0000);
    push_req(CMD_ERASE,  64'd0, 32'd0);
    push_req(CMD_INSERT, 64'd5, 32'hFFFF_FFFF);
    for (int i = 0; i < SLOTS - 2; i++) push_req(CMD_INSERT, 64'h100 + i, $urandom);
    push_req(CMD_INSERT, 64'hABCD, 32'd1);
    push_req(CMD_INSERT, 64'h100,  32'd2);
    push_req(CMD_ERASE,  64'h105,  32'd0);
    push_req(CMD_INSERT, 64'hABCD, 32'd3);
    push_req(CMD_NEXT,   64'hABCD, 32'd0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 87;
        end
        1: begin
          tx_idle_pct = 87;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      for (int i = 0; i < 400; i++) req_backlog.push_back(random_req());
      while (req_backlog.size() > 0 || n_taken != n_sent || due_results.size() > 0)
        @(posedge clk);
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0 && due_results.size() == 0) begin
      $display("** keyed_sequence_counter_table_top: PASSED **");
    end else begin
      $display("** keyed_sequence_counter_table_top: FAILED **");
    end
    $finish;
  end

endmodule
